// File: src/ppsch_pkg.sv
// Package for the preemptive priority scheduler: payload types, chain records and constants.
package ppsch_pkg;

	localparam int TIME_W = 16;
	localparam int SLOT_W = 4;
	localparam int PRIO_W = 8;
	// index carried along the chain, sized for the largest table (64 slots)
	localparam int IDX_W = 6;
	localparam int MAX_PROCS_DEF = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_time;
		logic [PRIO_W-1:0] priority_level;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] ran_slot;
		logic              idle;
		logic              finished;
		logic [TIME_W-1:0] wait_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] now_time;
	} rsp_t;

	// best ready slot seen so far, handed cell to cell
	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] wait_cnt;
		logic [TIME_W-1:0] burst;
		logic              last;
	} cand_t;

	// tick update broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} apply_t;

endpackage

// File: src/ppsch_cell.sv
// One process slot cell: holds slot state and passes the best candidate to its neighbor.
module ppsch_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ld_en,
	input  ppsch_pkg::req_t               ld,
	input  ppsch_pkg::apply_t             app,
	input  logic [ppsch_pkg::TIME_W-1:0]  now,
	input  ppsch_pkg::cand_t              cand_in,
	output ppsch_pkg::cand_t              cand_out
);

	localparam logic [ppsch_pkg::IDX_W-1:0] OWN_IDX = ppsch_pkg::IDX_W'(CELL_IDX);

	logic [ppsch_pkg::TIME_W-1:0] rem_q;
	logic [ppsch_pkg::TIME_W-1:0] wait_q;
	logic [ppsch_pkg::TIME_W-1:0] arr_q;
	logic [ppsch_pkg::TIME_W-1:0] bur_q;
	logic [ppsch_pkg::PRIO_W-1:0] pri_q;
	ppsch_pkg::cand_t             cand_q;

	logic ready;
	logic take;

	assign ready = (rem_q != '0) && (arr_q <= now);
	assign take  = ready && (!cand_in.found || (pri_q < cand_in.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			wait_q <= '0;
		end else if (ld_en) begin
			rem_q  <= ld.burst_time;
			wait_q <= '0;
		end else if (app.en) begin
			if (app.idx == OWN_IDX) begin
				rem_q <= rem_q - ppsch_pkg::TIME_W'(1);
			end else if (ready && (wait_q != ppsch_pkg::TIME_MAX)) begin
				wait_q <= wait_q + ppsch_pkg::TIME_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			arr_q <= ld.arrival_time;
			bur_q <= ld.burst_time;
			pri_q <= ld.priority_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (take) begin
			cand_q.found    <= 1'b1;
			cand_q.prio     <= pri_q;
			cand_q.idx      <= OWN_IDX;
			cand_q.wait_cnt <= wait_q;
			cand_q.burst    <= bur_q;
			cand_q.last     <= (rem_q == ppsch_pkg::TIME_W'(1));
		end else begin
			cand_q <= cand_in;
		end
	end

	assign cand_out = cand_q;

endmodule

// File: src/preemptive_priority_scheduler_core.sv
// Top level of the preemptive priority scheduler: slot cell chain, sequencer and result register.
// Load: accepted in IDLE, then the result is registered from the DONE state once the output can take it.
// Tick: passes through SCAN and then DONE, while the candidate chain carries the best slot
//   one cell per cycle; the update is applied to all cells in the result cycle.
// One transaction at a time; the next one is accepted while a result waits.
// Reset clears remaining work, wait counts and the tick counter; slot data is undefined.
module preemptive_priority_scheduler_core #(
	parameter int MAX_PROCS = ppsch_pkg::MAX_PROCS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ppsch_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ppsch_pkg::rsp_t rsp
);

	localparam int CNT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   st_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         op_q;
	logic [ppsch_pkg::TIME_W-1:0] tick_q;
	logic                         rsp_valid_q;
	ppsch_pkg::rsp_t              rsp_q;

	ppsch_pkg::cand_t  chain [MAX_PROCS+1];
	ppsch_pkg::apply_t app;
	ppsch_pkg::cand_t  best;
	ppsch_pkg::rsp_t   rsp_d;
	logic              accept;
	logic              can_out;
	logic              finish;
	logic [ppsch_pkg::TIME_W:0] tat_sum;

	assign req_stall = (st_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign can_out   = !rsp_valid_q || !rsp_stall;
	assign finish    = (st_q == ST_DONE) && can_out;

	assign chain[0] = '0;
	assign best     = chain[MAX_PROCS];

	assign app.en  = finish && (op_q == ppsch_pkg::OP_TICK) && best.found;
	assign app.idx = best.idx;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
			ppsch_cell #(
				.CELL_IDX(gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ld_en    (accept && (req.op == ppsch_pkg::OP_LOAD) &&
				           ({{(ppsch_pkg::IDX_W-ppsch_pkg::SLOT_W){1'b0}}, req.slot} ==
				            ppsch_pkg::IDX_W'(gi))),
				.ld       (req),
				.app      (app),
				.now      (tick_q),
				.cand_in  (chain[gi]),
				.cand_out (chain[gi+1])
			);
		end
	endgenerate

	assign tat_sum = {1'b0, best.wait_cnt} + {1'b0, best.burst};

	always_comb begin
		rsp_d = '0;
		rsp_d.idle = 1'b1;
		rsp_d.now_time = tick_q;
		if (op_q == ppsch_pkg::OP_TICK) begin
			rsp_d.now_time = tick_q + ppsch_pkg::TIME_W'(1);
			if (best.found) begin
				rsp_d.idle     = 1'b0;
				rsp_d.ran_slot = best.idx[ppsch_pkg::SLOT_W-1:0];
				if (best.last) begin
					rsp_d.finished  = 1'b1;
					rsp_d.wait_time = best.wait_cnt;
					rsp_d.turnaround_time = tat_sum[ppsch_pkg::TIME_W] ?
						ppsch_pkg::TIME_MAX : tat_sum[ppsch_pkg::TIME_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			op_q   <= ppsch_pkg::OP_LOAD;
			tick_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= req.op;
						cnt_q <= '0;
						st_q  <= (req.op == ppsch_pkg::OP_TICK) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(MAX_PROCS - 1)) begin
						st_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (can_out) begin
						st_q <= ST_IDLE;
						if (op_q == ppsch_pkg::OP_TICK) begin
							tick_q <= tick_q + ppsch_pkg::TIME_W'(1);
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
